@@ rtl/ssri_pkg.sv @@
// ----------------------------------------------------------------------------
// ssri_pkg
// shared types and constants of the stepper speed ramp interval core
// ----------------------------------------------------------------------------
package ssri_pkg;

	localparam int unsigned SPEED_BITS   = 8;
	localparam int unsigned PCT_BITS     = 7;
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned GROUP_BITS   = 5;

	// full speed in percent, and number of step groups before the count restarts
	localparam logic [SPEED_BITS-1:0] FULL_PCT = 8'd100;
	localparam logic [GROUP_BITS-1:0] GROUPS   = 5'd20;

	typedef enum logic [0:0] {
		OP_STEP  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef enum logic [0:0] {
		DIR_FWD = 1'b0,
		DIR_BWD = 1'b1
	} dir_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FWD_START = 3'd0,
		REG_FWD_END   = 3'd1,
		REG_FWD_INC   = 3'd2,
		REG_FWD_SKIP  = 3'd3,
		REG_BWD_START = 3'd4,
		REG_BWD_END   = 3'd5,
		REG_BWD_INC   = 3'd6,
		REG_BWD_SKIP  = 3'd7
	} cfg_idx_t;

endpackage

@@ rtl/stepper_speed_ramp_interval_core.sv @@
// ----------------------------------------------------------------------------
// stepper_speed_ramp_interval_core
// linear speed ramp for a stepper motor, one ramp for each direction
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | word
//  ---------+----------------------------+----------------------------------------
//  item     | item_valid / item_stall    | opcode, direction
//  result   | result_valid / result_stall| step_interval, speed_pct, ramp_complete
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  one word per cycle sustained while the result side does not stall and
//  no ramp point waits; an item passes the input register, then the
//  result register; the interval for the next ramp point comes from a
//  three-stage precompute per direction; a ramp point that grows the speed
//  waits in the input register until that direction's precompute has
//  settled after its last speed change, any register write or reset
//  reset clears the ramp state and loads the register defaults; no sweep
//  a stalled result holds the input register, which then stalls the item side
// ----------------------------------------------------------------------------
module stepper_speed_ramp_interval_core
	import ssri_pkg::*;
#(
	parameter int unsigned INTERVAL_BITS = 20,
	parameter int unsigned SKIP_BITS     = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     opcode,
	input  logic                     direction,

	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [INTERVAL_BITS-1:0] step_interval,
	output logic [SPEED_BITS-1:0]    speed_pct,
	output logic                     ramp_complete,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [(INTERVAL_BITS > SKIP_BITS ? INTERVAL_BITS : SKIP_BITS)-1:0] cfg_data
);

	localparam int unsigned COUNT_BITS = SKIP_BITS + GROUP_BITS;
	localparam logic [1:0]  AGE_FULL   = 2'd3;

	// configuration, indexed by direction
	logic [INTERVAL_BITS-1:0] start_q [2];
	logic [INTERVAL_BITS-1:0] end_q   [2];
	logic [PCT_BITS-1:0]      inc_q   [2];
	logic [SKIP_BITS-1:0]     skip_q  [2];

	// ramp state, indexed by direction
	logic [COUNT_BITS-1:0]    count_q [2];
	logic [SKIP_BITS-1:0]     phase_q [2];
	logic [SPEED_BITS-1:0]    speed_q [2];
	logic [INTERVAL_BITS-1:0] iv_q    [2];
	// cycles since the precompute operands last changed
	logic [1:0]               age_q   [2];
	logic [INTERVAL_BITS-1:0] next_iv [2];

	// input register
	logic                     valid_s1;
	opcode_t                  op_s1;
	dir_t                     dir_s1;

	// result register
	logic                     valid_s2;
	logic [INTERVAL_BITS-1:0] iv_s2;
	logic [SPEED_BITS-1:0]    speed_s2;
	logic                     done_s2;

	logic                     cfg_wr;
	logic                     item_acc;
	logic                     sel;
	logic [SKIP_BITS-1:0]     sk;
	logic [COUNT_BITS-1:0]    grp_lim;
	logic [COUNT_BITS-1:0]    count_base;
	logic [SKIP_BITS:0]       phase_inc;
	logic                     ramp_pt;
	logic                     grow;
	logic                     need_wait;
	logic                     go;
	logic [COUNT_BITS-1:0]    n_count;
	logic [SKIP_BITS-1:0]     n_phase;
	logic [SPEED_BITS-1:0]    n_speed;
	logic [INTERVAL_BITS-1:0] n_iv;
	logic                     spd_chg;

	// one precompute unit per direction, always running on the live state
	for (genvar d = 0; d < 2; d++) begin : g_calc
		ssri_ramp_calc #(
			.INTERVAL_BITS(INTERVAL_BITS)
		) u_calc (
			.clk     (clk),
			.start_iv(start_q[d]),
			.end_iv  (end_q[d]),
			.speed   (speed_q[d]),
			.inc     (inc_q[d]),
			.next_iv (next_iv[d])
		);
	end

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// step logic for the word held in the input register
	always_comb begin
		sel        = dir_s1;
		sk         = (skip_q[sel] == '0) ? SKIP_BITS'(1) : skip_q[sel];
		// twenty groups: 16 * sk + 4 * sk
		grp_lim    = (COUNT_BITS'(sk) << 4) + (COUNT_BITS'(sk) << 2);
		ramp_pt    = phase_q[sel] == '0;
		grow       = (op_s1 == OP_STEP) && ramp_pt && (speed_q[sel] < FULL_PCT);
		// a growing ramp point needs a settled precompute
		need_wait  = grow && (age_q[sel] != AGE_FULL);
		go         = valid_s1 && (!valid_s2 || !result_stall) && !need_wait;

		count_base = (ramp_pt && (count_q[sel] >= grp_lim)) ? '0 : count_q[sel];
		phase_inc  = (SKIP_BITS+1)'(phase_q[sel]) + (SKIP_BITS+1)'(1);

		n_count = count_q[sel];
		n_phase = phase_q[sel];
		n_speed = speed_q[sel];
		n_iv    = iv_q[sel];
		case (op_s1)
			OP_CLEAR: begin
				n_count = '0;
				n_phase = '0;
				n_speed = '0;
				n_iv    = start_q[sel];
			end
			OP_STEP: begin
				n_count = count_base + COUNT_BITS'(1);
				if (phase_inc >= (SKIP_BITS+1)'(sk))
					n_phase = '0;
				else
					n_phase = phase_inc[SKIP_BITS-1:0];
				if (grow) begin
					n_speed = speed_q[sel] + SPEED_BITS'(inc_q[sel]);
					n_iv    = next_iv[sel];
				end
			end
			default: begin
				n_count = count_q[sel];
			end
		endcase
		spd_chg = go && (n_speed != speed_q[sel]);
	end

	assign item_stall = valid_s1 && !go;
	assign item_acc   = item_valid && !item_stall;

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int d = 0; d < 2; d++) begin
				start_q[d] <= '0;
				end_q[d]   <= '0;
				inc_q[d]   <= PCT_BITS'(10);
				skip_q[d]  <= SKIP_BITS'(250);
				count_q[d] <= '0;
				phase_q[d] <= '0;
				speed_q[d] <= '0;
				iv_q[d]    <= '0;
				age_q[d]   <= '0;
			end
		end else begin
			// input register fills when free or when its word moves on
			if (item_acc)
				valid_s1 <= 1'b1;
			else if (go)
				valid_s1 <= 1'b0;

			if (go)
				valid_s2 <= 1'b1;
			else if (!result_stall)
				valid_s2 <= 1'b0;

			if (go) begin
				count_q[sel] <= n_count;
				phase_q[sel] <= n_phase;
				speed_q[sel] <= n_speed;
				iv_q[sel]    <= n_iv;
			end

			// operand change restarts the precompute settle count
			for (int d = 0; d < 2; d++) begin
				if (cfg_wr || (spd_chg && (sel == d[0])))
					age_q[d] <= '0;
				else if (age_q[d] != AGE_FULL)
					age_q[d] <= age_q[d] + 2'd1;
			end

			if (cfg_wr) begin
				case (cfg_idx_t'(cfg_index))
					REG_FWD_START: start_q[DIR_FWD] <= cfg_data[INTERVAL_BITS-1:0];
					REG_FWD_END:   end_q[DIR_FWD]   <= cfg_data[INTERVAL_BITS-1:0];
					REG_FWD_INC:   inc_q[DIR_FWD]   <= cfg_data[PCT_BITS-1:0];
					REG_FWD_SKIP:  skip_q[DIR_FWD]  <= cfg_data[SKIP_BITS-1:0];
					REG_BWD_START: start_q[DIR_BWD] <= cfg_data[INTERVAL_BITS-1:0];
					REG_BWD_END:   end_q[DIR_BWD]   <= cfg_data[INTERVAL_BITS-1:0];
					REG_BWD_INC:   inc_q[DIR_BWD]   <= cfg_data[PCT_BITS-1:0];
					REG_BWD_SKIP:  skip_q[DIR_BWD]  <= cfg_data[SKIP_BITS-1:0];
					default:       start_q[DIR_FWD] <= start_q[DIR_FWD];
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_s1  <= opcode_t'(opcode);
			dir_s1 <= dir_t'(direction);
		end
		if (go) begin
			iv_s2    <= n_iv;
			speed_s2 <= n_speed;
			done_s2  <= n_speed >= FULL_PCT;
		end
	end

	assign result_valid  = valid_s2;
	assign step_interval = iv_s2;
	assign speed_pct     = speed_s2;
	assign ramp_complete = done_s2;

endmodule

@@ rtl/ssri_ramp_calc.sv @@
// ----------------------------------------------------------------------------
// ssri_ramp_calc
// three-stage precompute of the interval at the next ramp point:
// start - trunc((start - end) * (speed + inc) / 100), clamped to the interval range
// ----------------------------------------------------------------------------
module ssri_ramp_calc
	import ssri_pkg::*;
#(
	parameter int unsigned INTERVAL_BITS = 20
) (
	input  logic                     clk,
	input  logic [INTERVAL_BITS-1:0] start_iv,
	input  logic [INTERVAL_BITS-1:0] end_iv,
	input  logic [SPEED_BITS-1:0]    speed,
	input  logic [PCT_BITS-1:0]      inc,
	output logic [INTERVAL_BITS-1:0] next_iv
);

	localparam int unsigned PROD_BITS  = INTERVAL_BITS + SPEED_BITS;
	// reciprocal of 100 exact for every product below 2^PROD_BITS
	localparam int unsigned SHIFT      = PROD_BITS + 7;
	localparam int unsigned RECIP_BITS = SHIFT - 6;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(FULL_PCT) - 64'd1) / 64'(FULL_PCT);
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];
	localparam int unsigned SCALE_BITS = PROD_BITS + RECIP_BITS;
	localparam int unsigned QUOT_BITS  = INTERVAL_BITS + 2;
	localparam logic [INTERVAL_BITS-1:0] IV_MAX = '1;

	logic                     neg;
	logic [INTERVAL_BITS-1:0] mag;
	logic [SPEED_BITS-1:0]    pct;

	logic [PROD_BITS-1:0]     prod_s1;
	logic                     neg_s1;
	logic [INTERVAL_BITS-1:0] start_s1;

	logic [SCALE_BITS-1:0]    scaled;
	logic [QUOT_BITS-1:0]     quot_s2;
	logic                     neg_s2;
	logic [INTERVAL_BITS-1:0] start_s2;

	logic [QUOT_BITS:0]       sum;
	logic [INTERVAL_BITS-1:0] result;
	logic [INTERVAL_BITS-1:0] next_iv_s3;

	// magnitude of the start-end difference, sign kept aside
	always_comb begin
		neg = end_iv > start_iv;
		mag = neg ? end_iv - start_iv : start_iv - end_iv;
		pct = speed + SPEED_BITS'(inc);
	end

	always_ff @(posedge clk) begin
		prod_s1  <= PROD_BITS'(mag) * PROD_BITS'(pct);
		neg_s1   <= neg;
		start_s1 <= start_iv;
	end

	assign scaled = SCALE_BITS'(prod_s1) * SCALE_BITS'(RECIP);

	always_ff @(posedge clk) begin
		quot_s2  <= scaled[SHIFT +: QUOT_BITS];
		neg_s2   <= neg_s1;
		start_s2 <= start_s1;
	end

	// apply the truncated quotient and saturate at both ends
	always_comb begin
		sum    = (QUOT_BITS+1)'(start_s2) + (QUOT_BITS+1)'(quot_s2);
		result = '0;
		if (neg_s2) begin
			if (sum > (QUOT_BITS+1)'(IV_MAX))
				result = IV_MAX;
			else
				result = sum[INTERVAL_BITS-1:0];
		end else begin
			if (quot_s2 > QUOT_BITS'(start_s2))
				result = '0;
			else
				result = start_s2 - quot_s2[INTERVAL_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		next_iv_s3 <= result;
	end

	assign next_iv = next_iv_s3;

endmodule

@@ sim/stepper_speed_ramp_interval_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_ramp_interval_core_tb
// self-checking bench for the forward and backward step interval ramps
//
// a queue-fed driver offers step and clear words with random gaps, and a
// monitor with random stalls checks every result word, field by field,
// against an in-bench ramp predictor; register settings change only between
// drained phases, and one phase holds the result side off for a long stretch
// ----------------------------------------------------------------------------
module stepper_speed_ramp_interval_core_tb;
	import ssri_pkg::*;

	localparam int unsigned IV_BITS       = 20;
	localparam int unsigned SK_BITS       = 16;
	localparam int unsigned CNT_BITS      = SK_BITS + GROUP_BITS;
	localparam logic [IV_BITS-1:0] IV_MAX = '1;
	localparam int unsigned RAND_PHASES   = 12;
	localparam int unsigned PHASE_WORDS   = 155;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned MAX_IDLE      = 16;

	typedef struct packed {
		opcode_t op;
		dir_t    dir;
	} step_word_t;

	typedef struct packed {
		logic [IV_BITS-1:0]    interval;
		logic [SPEED_BITS-1:0] pct;
		logic                  done;
	} ramp_word_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]   count;
		logic [SK_BITS-1:0]    phase;
		logic [SPEED_BITS-1:0] speed;
		logic [IV_BITS-1:0]    interval;
	} ramp_state_t;

	// dut signals; the inputs driven here are known from time zero
	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    item_valid   = 1'b0;
	logic                    item_stall;
	logic                    opcode       = 1'b0;
	logic                    direction    = 1'b0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [IV_BITS-1:0]      step_interval;
	logic [SPEED_BITS-1:0]   speed_pct;
	logic                    ramp_complete;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
	logic [IV_BITS-1:0]      cfg_data     = '0;

	// predictor copy of the register file, reset values
	logic [IV_BITS-1:0]  start_iv     [2] = '{default: '0};
	logic [IV_BITS-1:0]  end_iv       [2] = '{default: '0};
	logic [PCT_BITS-1:0] pct_inc      [2] = '{default: 7'd10};
	logic [SK_BITS-1:0]  steps_per_pt [2] = '{default: 16'd250};

	// predictor copy of the per-direction ramp state
	ramp_state_t ramp [2] = '{default: '0};

	step_word_t pending_words[$];
	ramp_word_t expected_words[$];
	step_word_t offered_word;
	ramp_word_t got_word;
	ramp_word_t want_word;

	int unsigned mismatches   = 0;
	int unsigned send_wait    = 0;
	int unsigned recv_wait    = 0;
	int unsigned hold_left    = 0;
	bit          word_offered = 1'b0;
	bit          send_idle    = 1'b0;
	bit          recv_idle    = 1'b0;
	bit          hold_arm     = 1'b0;
	bit          hold_done    = 1'b0;

	stepper_speed_ramp_interval_core #(
		.INTERVAL_BITS (IV_BITS),
		.SKIP_BITS     (SK_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.opcode        (opcode),
		.direction     (direction),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.step_interval (step_interval),
		.speed_pct     (speed_pct),
		.ramp_complete (ramp_complete),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 100 MHz
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// ramp predictor
	// ------------------------------------------------------------------------

	// start - (start - end) * pct / 100, truncated toward zero, then clamped
	// to the interval range; pct above 100 can overshoot either way
	function automatic logic [IV_BITS-1:0] interval_at(input logic [IV_BITS-1:0] s,
			input logic [IV_BITS-1:0] e, input logic [SPEED_BITS-1:0] pct);
		longint span;
		longint drop;
		longint val;
		span = longint'(s) - longint'(e);
		drop = span * longint'(pct) / 100;
		val  = longint'(s) - drop;
		if (val < 0)
			return '0;
		if (val > longint'(IV_MAX))
			return IV_MAX;
		return val[IV_BITS-1:0];
	endfunction

	// one accepted word in, the result word it causes out
	function automatic ramp_word_t predict_ramp(input step_word_t w);
		ramp_state_t st;
		int unsigned sk;
		ramp_word_t  res;
		st = ramp[w.dir];
		// zero steps per ramp point behaves as one
		sk = (steps_per_pt[w.dir] == 0) ? 1 : steps_per_pt[w.dir];
		if (w.op == OP_CLEAR) begin
			st          = '0;
			st.interval = start_iv[w.dir];
		end else begin
			if (st.phase == 0) begin
				// ramp point: grow only while below full speed
				if (st.speed < FULL_PCT) begin
					st.speed    = st.speed + pct_inc[w.dir];
					st.interval = interval_at(start_iv[w.dir], end_iv[w.dir], st.speed);
				end
				if (st.count >= sk * GROUPS)
					st.count = '0;
			end
			st.count = st.count + 1'b1;
			// a phase left above a lowered step count falls back to zero here
			st.phase = (st.phase + 1 >= sk) ? '0 : st.phase + 1'b1;
		end
		ramp[w.dir]  = st;
		res.interval = st.interval;
		res.pct      = st.speed;
		res.done     = (st.speed >= FULL_PCT);
		return res;
	endfunction

	function automatic void set_reg(input cfg_idx_t idx, input logic [IV_BITS-1:0] val);
		case (idx)
			REG_FWD_START: start_iv[DIR_FWD]     = val;
			REG_FWD_END:   end_iv[DIR_FWD]       = val;
			REG_FWD_INC:   pct_inc[DIR_FWD]      = val[PCT_BITS-1:0];
			REG_FWD_SKIP:  steps_per_pt[DIR_FWD] = val[SK_BITS-1:0];
			REG_BWD_START: start_iv[DIR_BWD]     = val;
			REG_BWD_END:   end_iv[DIR_BWD]       = val;
			REG_BWD_INC:   pct_inc[DIR_BWD]      = val[PCT_BITS-1:0];
			REG_BWD_SKIP:  steps_per_pt[DIR_BWD] = val[SK_BITS-1:0];
			default: ;
		endcase
	endfunction

	// random register value, weighted toward the edges of each range
	function automatic logic [IV_BITS-1:0] pick_value(input cfg_idx_t idx);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (idx == REG_FWD_INC || idx == REG_BWD_INC) begin
			if (roll == 0)
				return '0;
			if (roll == 1)
				return IV_BITS'(100);
			if (roll == 2)
				return IV_BITS'($urandom_range(101, 127));
			return IV_BITS'($urandom_range(1, 100));
		end
		if (idx == REG_FWD_SKIP || idx == REG_BWD_SKIP) begin
			// mostly short groups so ramps finish within a phase
			if (roll == 0)
				return '0;
			if (roll == 1)
				return IV_BITS'($urandom_range(9, 64));
			if (roll == 2)
				return IV_BITS'($urandom_range(0, 65535));
			return IV_BITS'($urandom_range(1, 8));
		end
		if (roll == 0)
			return '0;
		if (roll == 1)
			return IV_MAX;
		return IV_BITS'($urandom_range(0, IV_MAX));
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	task automatic push_word(input opcode_t op, input dir_t dir);
		pending_words.push_back('{op: op, dir: dir});
	endtask

	// register write, only called with the block idle
	task automatic write_reg(input cfg_idx_t idx, input logic [IV_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		set_reg(idx, val);
	endtask

	// wait until every queued word is in and every result is back, then
	// let the precompute settle so no ramp point is still pending
	task automatic drain_words();
		while (pending_words.size() != 0 || word_offered || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// item driver
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			opcode     <= OP_STEP;
			direction  <= DIR_FWD;
		end else begin
			// word taken this edge: predict its result now
			if (item_valid && !item_stall) begin
				expected_words.push_back(predict_ramp(offered_word));
				word_offered = 1'b0;
			end
			// a stalled word stays put; otherwise idle out the gap or offer the next
			if (!item_valid || !item_stall) begin
				if (send_wait != 0) begin
					send_wait--;
					item_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					offered_word = pending_words.pop_front();
					opcode       <= offered_word.op;
					direction    <= offered_word.dir;
					item_valid   <= 1'b1;
					word_offered = 1'b1;
					send_wait    = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// long result hold-off, counted here so the block backs up to its input
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------------
	// result monitor and checker
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				got_word = '{interval: step_interval, pct: speed_pct, done: ramp_complete};
				if (expected_words.size() == 0) begin
					// result with nothing outstanding
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected word: interval %0d pct %0d complete %0b",
							$realtime, got_word.interval, got_word.pct, got_word.done);
				end else begin
					want_word = expected_words.pop_front();
					if (got_word.interval !== want_word.interval ||
							got_word.pct !== want_word.pct ||
							got_word.done !== want_word.done) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: mismatch: interval %0d/%0d pct %0d/%0d complete %0b/%0b (exp/act)",
								$realtime, want_word.interval, got_word.interval,
								want_word.pct, got_word.pct, want_word.done, got_word.done);
					end
				end
				recv_wait = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			result_stall <= (recv_wait != 0) || (hold_left != 0);
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		step_word_t w;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero intervals, default increment and group size
		push_word(OP_STEP, DIR_FWD);
		push_word(OP_CLEAR, DIR_BWD);
		drain_words();

		// falling ramp overshoots below zero, rising ramp overshoots the top;
		// forward with zero group size so every step is a ramp point
		write_reg(REG_FWD_START, IV_MAX);
		write_reg(REG_FWD_END, '0);
		write_reg(REG_FWD_INC, 60);
		write_reg(REG_FWD_SKIP, '0);
		write_reg(REG_BWD_START, '0);
		write_reg(REG_BWD_END, IV_MAX);
		write_reg(REG_BWD_INC, 60);
		write_reg(REG_BWD_SKIP, 1);
		push_word(OP_CLEAR, DIR_FWD);
		push_word(OP_CLEAR, DIR_BWD);
		repeat (3) push_word(OP_STEP, DIR_FWD);
		repeat (3) push_word(OP_STEP, DIR_BWD);
		drain_words();

		// zero increment, then leave the forward ramp in mid-group
		write_reg(REG_FWD_START, 12345);
		write_reg(REG_FWD_END, 777);
		write_reg(REG_FWD_INC, '0);
		write_reg(REG_FWD_SKIP, 5);
		push_word(OP_CLEAR, DIR_FWD);
		repeat (3) push_word(OP_STEP, DIR_FWD);
		drain_words();

		// group size lowered below the current phase, full increment;
		// backward with the widest group
		write_reg(REG_FWD_SKIP, 2);
		write_reg(REG_FWD_INC, 100);
		write_reg(REG_BWD_SKIP, 16'hffff);
		write_reg(REG_BWD_INC, 1);
		repeat (3) push_word(OP_STEP, DIR_FWD);
		push_word(OP_CLEAR, DIR_BWD);
		repeat (2) push_word(OP_STEP, DIR_BWD);
		drain_words();

		// random phases: first with no idling, then both sides idling, then
		// a back-to-back sender against a long result hold-off, then random idling
		for (int unsigned p = 0; p < RAND_PHASES; p++) begin
			send_idle <= (p == 1) || (p > 2 && $urandom_range(0, 3) != 0);
			recv_idle <= (p == 1) || (p > 2 && $urandom_range(0, 3) != 0);
			// a register left alone keeps the ramps where the last phase put them
			for (int unsigned r = 0; r < 8; r++)
				if (p == 0 || $urandom_range(0, 3) != 0)
					write_reg(cfg_idx_t'(r), pick_value(cfg_idx_t'(r)));
			if (p == 2)
				hold_arm <= 1'b1;
			// step runs in one direction, broken by switches and clears
			w.dir = dir_t'($urandom_range(0, 1));
			for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
				if ($urandom_range(0, 3) == 0)
					w.dir = dir_t'($urandom_range(0, 1));
				w.op = ($urandom_range(0, 99) < 8) ? OP_CLEAR : OP_STEP;
				pending_words.push_back(w);
			end
			drain_words();
		end

		if (mismatches == 0 && expected_words.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ssri_pkg.sv
rtl/ssri_ramp_calc.sv
rtl/stepper_speed_ramp_interval_core.sv
sim/stepper_speed_ramp_interval_core_tb.sv
